@@ rtl/core/fsnf_pkg.sv @@
// Package for the FAT short name formatter: transaction structs, byte constants
// and the illegal-byte test. It has no dependencies.
package fsnf_pkg;

    localparam int unsigned NAME_LEN  = 8;
    localparam int unsigned EXT_LEN   = 3;
    localparam int unsigned NUM_CHARS = NAME_LEN + 1 + EXT_LEN;
    localparam int unsigned CNT_W     = $clog2(NUM_CHARS + 1);
    localparam int unsigned IDX_W     = $clog2(NUM_CHARS);

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] DOT_BYTE   = 8'h2E;
    localparam logic [7:0] ESC_IN     = 8'h05;
    localparam logic [7:0] ESC_OUT    = 8'hE5;

    typedef struct packed {
        logic [63:0] name_part;
        logic [23:0] ext_part;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_char;
        logic       bad_name;
    } t_out_item;

    // One formatted name, ready to be sent out one character at a time.
    typedef struct packed {
        logic [NUM_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          cnt;
        logic                      bad;
    } t_fmt_name;

    // Control bytes and the punctuation that a short name may not contain.
    function automatic logic byte_is_illegal(input logic [7:0] b);
        return (b < SPACE_BYTE) ||
               (b inside {8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B,
                          8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C});
    endfunction

endpackage

@@ rtl/core/fsnf_format.sv @@
// Combinational formatter: turns the eleven raw bytes of a short name into the
// list of output characters, its length and the error flag. Depends on fsnf_pkg.
module fsnf_format (
    input  fsnf_pkg::t_in_item  i_item,
    output fsnf_pkg::t_fmt_name o_fmt
);
    import fsnf_pkg::*;

    logic [NAME_LEN-1:0][7:0] name_b;
    logic [EXT_LEN-1:0][7:0]  ext_b;
    logic                     bad;
    logic [CNT_W-1:0]         name_len;
    logic [CNT_W-1:0]         ext_len;
    logic                     has_ext;
    logic                     name_done;
    logic                     ext_done;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         ext_pos;

    always_comb begin
        name_b = i_item.name_part;
        ext_b  = i_item.ext_part;
        if (name_b[0] == ESC_IN) begin
            name_b[0] = ESC_OUT;
        end

        // Every byte is checked, also those behind the space that ends a part.
        bad = (name_b[0] == SPACE_BYTE);
        for (int i = 0; i < NAME_LEN; i++) begin
            bad = bad | byte_is_illegal(name_b[i]);
        end
        for (int i = 0; i < EXT_LEN; i++) begin
            bad = bad | byte_is_illegal(ext_b[i]);
        end

        name_len  = '0;
        name_done = 1'b0;
        for (int i = 0; i < NAME_LEN; i++) begin
            if (name_b[i] == SPACE_BYTE) begin
                name_done = 1'b1;
            end
            if (!name_done) begin
                name_len = name_len + 1'b1;
            end
        end

        ext_len  = '0;
        ext_done = 1'b0;
        for (int i = 0; i < EXT_LEN; i++) begin
            if (ext_b[i] == SPACE_BYTE) begin
                ext_done = 1'b1;
            end
            if (!ext_done) begin
                ext_len = ext_len + 1'b1;
            end
        end
        has_ext = (ext_b[0] != SPACE_BYTE);

        // Character k is a name byte, the dot, or an extension byte.
        o_fmt.chars = '0;
        for (int k = 0; k < NUM_CHARS; k++) begin
            pos     = CNT_W'(k);
            ext_pos = pos - name_len - 1'b1;
            if (pos < name_len) begin
                o_fmt.chars[k] = name_b[pos[2:0]];
            end else if (pos == name_len) begin
                o_fmt.chars[k] = DOT_BYTE;
            end else if (ext_pos < CNT_W'(EXT_LEN)) begin
                o_fmt.chars[k] = ext_b[ext_pos[1:0]];
            end
        end

        if (bad) begin
            o_fmt.chars = '0;
            o_fmt.cnt   = CNT_W'(1);
        end else if (has_ext) begin
            o_fmt.cnt = name_len + ext_len + 1'b1;
        end else begin
            o_fmt.cnt = name_len;
        end
        o_fmt.bad = bad;
    end

endmodule

@@ rtl/core/fsnf_serializer.sv @@
// Character serializer: holds one formatted name and sends its characters one
// per cycle when not stalled, via a registered output stage. Depends on fsnf_pkg.
module fsnf_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fmt_valid,
    input  fsnf_pkg::t_fmt_name i_fmt,
    output logic                o_fmt_take,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fsnf_pkg::t_out_item o_out_data
);
    import fsnf_pkg::*;

    logic                      r_busy;
    logic [NUM_CHARS-1:0][7:0] r_chars;
    logic [CNT_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_bad;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic out_free;
    logic emit;
    logic is_last;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = r_busy && out_free;
    assign is_last    = (r_idx == IDX_W'(r_cnt - 1'b1));
    // A new name is loaded in the same cycle as the previous one's last character.
    assign o_fmt_take = i_fmt_valid && (!r_busy || (emit && is_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_fmt_take) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fmt_take) begin
            r_chars <= i_fmt.chars;
            r_cnt   <= i_fmt.cnt;
            r_bad   <= i_fmt.bad;
            r_idx   <= '0;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (emit) begin
            r_out.char_out  <= r_chars[r_idx];
            r_out.last_char <= is_last;
            r_out.bad_name  <= r_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/fat_short_name_formatter_top.sv @@
// Top level of the FAT 8.3 short name formatter: input register, formatter and
// character serializer. Depends on fsnf_pkg, fsnf_format and fsnf_serializer.
//
// Usage:
//   The input channel (i_in_valid, o_in_stall, i_in_data) carries one transaction
//   per short name: the eight name bytes and the three extension bytes as stored
//   in a directory entry. The output channel (o_out_valid, i_out_stall,
//   o_out_data) carries one transaction per character of the dotted file name;
//   last_char marks the final one. A rejected name gives a single transaction
//   with char_out zero and both last_char and bad_name set.
//   The first character of a name passes through the input register, the
//   serializer's character store and the output register; the serializer
//   sends one character per cycle while the output is not stalled, so a name
//   of 1 to 12 characters occupies it until its last character goes out, and
//   the next name is loaded in that same cycle, with no gap. One name waits
//   in the input register meanwhile, and o_in_stall rises only when that
//   register is full and cannot hand its name over.
//   A stall on the output holds the output register and its payload steady and,
//   once the input register is full, backs up to o_in_stall.
//   Reset (synchronous, active low) empties the input register, the serializer
//   and the output register; no transaction in flight survives it.
module fat_short_name_formatter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fsnf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fsnf_pkg::t_out_item o_out_data
);
    import fsnf_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      n_in_valid;
    logic      in_accept;
    logic      fmt_take;
    t_fmt_name fmt;

    // The input register can take a new name when it is empty or when its
    // current name moves into the serializer in this cycle.
    assign o_in_stall = r_in_valid && !fmt_take;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (fmt_take) begin
            n_in_valid = 1'b0;
        end
        if (in_accept) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // Short combinational pass from the input register to the character list.
    fsnf_format u_format (
        .i_item (r_in),
        .o_fmt  (fmt)
    );

    fsnf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt_valid (r_in_valid),
        .i_fmt       (fmt),
        .o_fmt_take  (fmt_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
